/* rtl/swts_pkg.sv */
// shared constants, types and codes of the window transfer splitter
package swts_pkg;

	// geometry (block and window sizes are powers of two)
	localparam int BLOCK_BYTES  = 64;
	localparam int WINDOW_BYTES = 32768;
	localparam int MAX_BLOCKS   = 512;

	localparam int BLOCK_LOG2 = $clog2(BLOCK_BYTES);
	localparam int WIN_LOG2   = $clog2(WINDOW_BYTES);

	// field widths
	localparam int ADDR_W  = 32;
	localparam int LEN_W   = 16;
	localparam int CHUNK_W = 16;
	localparam int BCNT_W  = 10;
	localparam int CMD_W   = 6;
	localparam int MODE_W  = 6;
	localparam int BSZ_W   = 16;
	localparam int WBASE_W = ADDR_W - WIN_LOG2;
	localparam int CNT_W   = 4;
	localparam int WIN_K_W = 2;

	localparam logic [CNT_W-1:0]   RESULT_CAP  = 4'd15;
	localparam logic [WIN_K_W-1:0] WIN_K_LAST  = 2'd2;
	localparam logic [ADDR_W-1:0]  WINDOW_SIZE = ADDR_W'(WINDOW_BYTES);
	localparam logic [ADDR_W-1:0]  MAX_CHUNK   = ADDR_W'(MAX_BLOCKS * BLOCK_BYTES);
	localparam logic [ADDR_W-1:0]  BLOCK_SIZE  = ADDR_W'(BLOCK_BYTES);
	localparam logic [CHUNK_W-1:0] BLOCK_MASK  = ~CHUNK_W'(BLOCK_BYTES - 1);

	// card register map
	localparam logic [16:0] WIN_REG_ADDR = 17'h1000A;
	localparam logic [16:0] WIN_OFFSET   = 17'h08000;
	localparam logic [BSZ_W-1:0] BSZ_TAG = 16'h7000;

	// command codes
	localparam logic [CMD_W-1:0] CMD_DIRECT   = 6'd52;
	localparam logic [CMD_W-1:0] CMD_EXTENDED = 6'd53;

	// transfer mode bits
	localparam logic [MODE_W-1:0] MODE_DMA     = 6'h01;
	localparam logic [MODE_W-1:0] MODE_BCNT_EN = 6'h02;
	localparam logic [MODE_W-1:0] MODE_READ    = 6'h10;
	localparam logic [MODE_W-1:0] MODE_MULTI   = 6'h20;

	// command argument bits
	localparam logic [31:0] ARG_WRITE = 32'h8000_0000;
	localparam logic [31:0] ARG_FN1   = 32'h1000_0000;
	localparam logic [31:0] ARG_BLOCK = 32'h0800_0000;
	localparam logic [31:0] ARG_INCR  = 32'h0400_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LIMIT,
		ST_CLAMP,
		ST_ROUND,
		ST_WIN,
		ST_DATA,
		ST_REM,
		ST_ADDR,
		ST_HOST
	} seq_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
		logic              sub;
	} alu_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] sum;
		logic              carry;
	} alu_rsp_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command_index;
		logic [31:0]        command_argument;
		logic [MODE_W-1:0]  transfer_mode;
		logic [BSZ_W-1:0]   block_size_word;
		logic [BCNT_W-1:0]  block_count;
		logic [ADDR_W-1:0]  dma_address;
		logic [CHUNK_W-1:0] chunk_bytes;
		logic               last;
	} result_t;

endpackage

/* rtl/swts_alu.sv */
// shared 32-bit add/subtract unit with carry out
module swts_alu (
	input  swts_pkg::alu_req_t req,
	output swts_pkg::alu_rsp_t rsp
);

	logic [swts_pkg::ADDR_W-1:0] b_op;
	logic [swts_pkg::ADDR_W:0]   total;

	assign b_op  = req.sub ? ~req.b : req.b;
	assign total = {1'b0, req.a} + {1'b0, b_op} + {{swts_pkg::ADDR_W{1'b0}}, req.sub};

	assign rsp.sum   = total[swts_pkg::ADDR_W-1:0];
	assign rsp.carry = total[swts_pkg::ADDR_W];

endmodule

/* rtl/swts_seq.sv */
// chunk sequencer: splits a request and builds each command
module swts_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          is_write,
	input  logic [swts_pkg::ADDR_W-1:0]   card_address,
	input  logic [swts_pkg::LEN_W-1:0]    length,
	input  logic [swts_pkg::ADDR_W-1:0]   host_address,
	output swts_pkg::alu_req_t            alu_req,
	input  swts_pkg::alu_rsp_t            alu_rsp,
	output logic                          res_valid,
	output swts_pkg::result_t             res,
	input  logic                          res_free
);

	swts_pkg::seq_state_t state_q, state_d;

	logic                            wr_q;
	logic [swts_pkg::ADDR_W-1:0]     addr_q;
	logic [swts_pkg::ADDR_W-1:0]     host_q;
	logic [swts_pkg::LEN_W-1:0]      rem_q;
	logic [swts_pkg::CHUNK_W-1:0]    lim_q;
	logic [swts_pkg::CHUNK_W-1:0]    chunk_q;
	logic [swts_pkg::WIN_K_W-1:0]    win_k_q;
	logic [swts_pkg::CNT_W-1:0]      cnt_q;
	logic [swts_pkg::WBASE_W-1:0]    window_base_q;

	logic                            capped;
	logic                            adv;
	logic                            rem_gt_lim;
	logic [swts_pkg::CHUNK_W-1:0]    rounded;
	logic [swts_pkg::WBASE_W-1:0]    base_hi;
	logic [swts_pkg::ADDR_W-1:0]     base_full;
	logic [16:0]                     off_ext;
	logic [7:0]                      win_byte;
	logic [swts_pkg::BCNT_W-1:0]     blocks;
	logic                            block_mode;

	assign base_hi   = addr_q[swts_pkg::ADDR_W-1:swts_pkg::WIN_LOG2];
	assign base_full = {base_hi, {swts_pkg::WIN_LOG2{1'b0}}};
	assign off_ext   = 17'(addr_q[swts_pkg::WIN_LOG2-1:0]);

	assign capped     = (cnt_q == swts_pkg::RESULT_CAP);
	assign adv        = capped || res_free;
	assign rem_gt_lim = alu_rsp.carry && (alu_rsp.sum != '0);
	assign in_stall   = (state_q != swts_pkg::ST_IDLE);

	assign blocks     = swts_pkg::BCNT_W'(chunk_q >> swts_pkg::BLOCK_LOG2);
	assign block_mode = ({16'b0, chunk_q} >= swts_pkg::BLOCK_SIZE);

	// round chunks above one block down to whole blocks, then cap at the block limit
	always_comb begin
		rounded = chunk_q;
		if ({16'b0, rounded} > swts_pkg::BLOCK_SIZE)
			rounded = rounded & swts_pkg::BLOCK_MASK;
		if ({16'b0, rounded} > swts_pkg::MAX_CHUNK)
			rounded = swts_pkg::MAX_CHUNK[swts_pkg::CHUNK_W-1:0];
	end

	always_comb begin
		case (win_k_q)
			2'd0:    win_byte = base_full[15:8];
			2'd1:    win_byte = base_full[23:16];
			default: win_byte = base_full[31:24];
		endcase
	end

	// next state, shared unit operands, command build
	always_comb begin
		state_d     = state_q;
		alu_req.a   = '0;
		alu_req.b   = '0;
		alu_req.sub = 1'b0;
		res_valid   = 1'b0;
		res         = '0;
		unique case (state_q)
			swts_pkg::ST_IDLE: begin
				if (in_valid && (length != '0))
					state_d = swts_pkg::ST_LIMIT;
			end
			swts_pkg::ST_LIMIT: begin
				alu_req.a   = swts_pkg::WINDOW_SIZE;
				alu_req.b   = 32'(off_ext);
				alu_req.sub = 1'b1;
				state_d     = swts_pkg::ST_CLAMP;
			end
			swts_pkg::ST_CLAMP: begin
				alu_req.a   = 32'(rem_q);
				alu_req.b   = 32'(lim_q);
				alu_req.sub = 1'b1;
				state_d     = swts_pkg::ST_ROUND;
			end
			swts_pkg::ST_ROUND: begin
				if (base_hi != window_base_q)
					state_d = swts_pkg::ST_WIN;
				else
					state_d = swts_pkg::ST_DATA;
			end
			swts_pkg::ST_WIN: begin
				res_valid                 = !capped;
				res.command_index         = swts_pkg::CMD_DIRECT;
				res.command_argument      = swts_pkg::ARG_WRITE | swts_pkg::ARG_FN1 |
					{6'b0, swts_pkg::WIN_REG_ADDR + 17'(win_k_q), 1'b0, win_byte};
				res.last                  = (cnt_q == swts_pkg::RESULT_CAP - 4'd1);
				if (adv && (win_k_q == swts_pkg::WIN_K_LAST))
					state_d = swts_pkg::ST_DATA;
			end
			swts_pkg::ST_DATA: begin
				res_valid            = !capped;
				res.command_index    = swts_pkg::CMD_EXTENDED;
				res.command_argument = (wr_q ? swts_pkg::ARG_WRITE : 32'h0) |
					swts_pkg::ARG_FN1 | swts_pkg::ARG_INCR |
					{6'b0, off_ext | swts_pkg::WIN_OFFSET, 9'b0};
				res.transfer_mode    = wr_q ? '0 : swts_pkg::MODE_READ;
				res.chunk_bytes      = chunk_q;
				res.last             = (16'(chunk_q) == rem_q) ||
					(cnt_q == swts_pkg::RESULT_CAP - 4'd1);
				if (block_mode) begin
					res.command_argument = res.command_argument | swts_pkg::ARG_BLOCK |
						{23'b0, blocks[8:0]};
					res.transfer_mode    = res.transfer_mode | swts_pkg::MODE_DMA;
					if (blocks > 10'd1)
						res.transfer_mode = res.transfer_mode | swts_pkg::MODE_MULTI |
							swts_pkg::MODE_BCNT_EN;
					res.block_size_word  = swts_pkg::BLOCK_SIZE[swts_pkg::BSZ_W-1:0] |
						swts_pkg::BSZ_TAG;
					res.block_count      = blocks;
					res.dma_address      = host_q;
				end else begin
					res.command_argument = res.command_argument | {23'b0, chunk_q[8:0]};
					res.block_size_word  = chunk_q | swts_pkg::BSZ_TAG;
					res.block_count      = 10'd1;
				end
				if (adv)
					state_d = swts_pkg::ST_REM;
			end
			swts_pkg::ST_REM: begin
				alu_req.a   = 32'(rem_q);
				alu_req.b   = 32'(chunk_q);
				alu_req.sub = 1'b1;
				state_d     = swts_pkg::ST_ADDR;
			end
			swts_pkg::ST_ADDR: begin
				alu_req.a = addr_q;
				alu_req.b = 32'(chunk_q);
				state_d   = swts_pkg::ST_HOST;
			end
			swts_pkg::ST_HOST: begin
				alu_req.a = host_q;
				alu_req.b = 32'(chunk_q);
				if (rem_q == '0)
					state_d = swts_pkg::ST_IDLE;
				else
					state_d = swts_pkg::ST_LIMIT;
			end
			default: state_d = swts_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= swts_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// control counters and stored window base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_k_q       <= '0;
			cnt_q         <= '0;
			window_base_q <= '0;
		end else begin
			unique case (state_q)
				swts_pkg::ST_IDLE: begin
					if (in_valid)
						cnt_q <= '0;
				end
				swts_pkg::ST_ROUND: win_k_q <= '0;
				swts_pkg::ST_WIN: begin
					if (adv) begin
						if (!capped)
							cnt_q <= cnt_q + 4'd1;
						win_k_q <= win_k_q + 2'd1;
						if (win_k_q == swts_pkg::WIN_K_LAST)
							window_base_q <= base_hi;
					end
				end
				swts_pkg::ST_DATA: begin
					if (adv && !capped)
						cnt_q <= cnt_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	// working registers of the request
	always_ff @(posedge clk) begin
		unique case (state_q)
			swts_pkg::ST_IDLE: begin
				if (in_valid) begin
					wr_q   <= is_write;
					addr_q <= card_address;
					rem_q  <= length;
					host_q <= host_address;
				end
			end
			swts_pkg::ST_LIMIT: lim_q   <= alu_rsp.sum[swts_pkg::CHUNK_W-1:0];
			swts_pkg::ST_CLAMP: chunk_q <= rem_gt_lim ? lim_q : 16'(rem_q);
			swts_pkg::ST_ROUND: chunk_q <= rounded;
			swts_pkg::ST_REM:   rem_q   <= alu_rsp.sum[swts_pkg::LEN_W-1:0];
			swts_pkg::ST_ADDR:  addr_q  <= alu_rsp.sum;
			swts_pkg::ST_HOST:  host_q  <= alu_rsp.sum;
			default: ;
		endcase
	end

	a_chunk_sane: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swts_pkg::ST_DATA |-> (chunk_q != '0) && (16'(chunk_q) <= rem_q))
		else $error("chunk empty or larger than remaining length");

	a_no_emit_past_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !capped)
		else $error("command offered beyond result cap");

	a_window_written: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swts_pkg::ST_WIN && adv && win_k_q == swts_pkg::WIN_K_LAST) |=>
		(state_q == swts_pkg::ST_DATA && window_base_q == base_hi))
		else $error("window base not updated before data command");

	a_win_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swts_pkg::ST_WIN |-> win_k_q <= swts_pkg::WIN_K_LAST)
		else $error("window byte counter out of range");

endmodule

/* rtl/sdio_window_transfer_splitter_top.sv */
// top level of the windowed sdio transfer splitter with its output register
// One transaction on the input channel is a memory transfer request (direction,
// card address, length, host address); it is expanded into the sdio command
// sequence that moves it, one command per output transaction. The request is cut
// at every 32 KiB window boundary, chunks above one 64-byte block are rounded down
// to whole blocks (and capped at the block limit), and a shorter tail goes out as
// a byte-mode pio command. Whenever the window base changes, three direct byte
// writes programme the window registers before the extended command of that chunk;
// the stored window base resets to zero. A zero length is absorbed and gives no
// output transaction; at most fifteen commands are given per request, the final
// one carrying last. The block takes one request at a time: in_stall is high from
// acceptance until the sequencer has finished the request. Every chunk runs through
// a small sequencer around a single shared 32-bit add/subtract unit: window limit,
// clamp to remaining length, block rounding, optional window writes, the extended
// command, then updates of remaining length, card address and host address; an output
// stall can hold the sequencer on the window writes and the extended command. The next
// request is taken in the idle state after the host address update, and a zero length
// request is absorbed in the idle state. The last command sits in an output register,
// so output stalls only hold the sequencer when that register is full.
module sdio_window_transfer_splitter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        is_write,
	input  logic [31:0] card_address,
	input  logic [15:0] length,
	input  logic [31:0] host_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  command_index,
	output logic [31:0] command_argument,
	output logic [5:0]  transfer_mode,
	output logic [15:0] block_size_word,
	output logic [9:0]  block_count,
	output logic [31:0] dma_address,
	output logic [15:0] chunk_bytes,
	output logic        last
);

	swts_pkg::alu_req_t alu_req;
	swts_pkg::alu_rsp_t alu_rsp;
	swts_pkg::result_t  res;
	swts_pkg::result_t  res_q;
	logic               res_valid;
	logic               res_free;
	logic               out_valid_q;

	// shared arithmetic unit
	swts_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// chunk sequencer
	swts_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.is_write     (is_write),
		.card_address (card_address),
		.length       (length),
		.host_address (host_address),
		.alu_req      (alu_req),
		.alu_rsp      (alu_rsp),
		.res_valid    (res_valid),
		.res          (res),
		.res_free     (res_free)
	);

	// output register can take a new command when empty or being drained
	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_valid && res_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// payload held while the transaction is stalled
	always_ff @(posedge clk) begin
		if (res_valid && res_free)
			res_q <= res;
	end

	assign out_valid        = out_valid_q;
	assign command_index    = res_q.command_index;
	assign command_argument = res_q.command_argument;
	assign transfer_mode    = res_q.transfer_mode;
	assign block_size_word  = res_q.block_size_word;
	assign block_count      = res_q.block_count;
	assign dma_address      = res_q.dma_address;
	assign chunk_bytes      = res_q.chunk_bytes;
	assign last             = res_q.last;

endmodule

/* verif/sdio_window_transfer_splitter_top_tb.sv */
// self-checking testbench of the windowed sdio transfer splitter top level
module sdio_window_transfer_splitter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// idling phases, cycled every few dozen requests
	typedef enum logic [1:0] {
		PH_QUIET,
		PH_SEND,
		PH_RECV,
		PH_BOTH
	} idle_phase_t;

	localparam int PHASE_REQS     = 40;   // requests per idling phase
	localparam int SINGLE_PCT     = 56;   // idle or stall rate with one side idling
	localparam int BOTH_PCT       = 35;   // rate on each side with both idling
	localparam int RANDOM_REQS    = 295;
	localparam int TAIL_CYCLES    = 80;   // covers the longest request the block can chew on
	localparam int WATCHDOG_LIMIT = 3000;

	// one memory transfer request, plus a flag that holds the sender until the block is empty
	typedef struct {
		logic        is_write;
		logic [31:0] card_address;
		logic [15:0] length;
		logic [31:0] host_address;
		bit          drain_first;
	} request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        is_write = 1'b0;
	logic [31:0] card_address = '0;
	logic [15:0] length = '0;
	logic [31:0] host_address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [5:0]  command_index;
	logic [31:0] command_argument;
	logic [5:0]  transfer_mode;
	logic [15:0] block_size_word;
	logic [9:0]  block_count;
	logic [31:0] dma_address;
	logic [15:0] chunk_bytes;
	logic        last;

	request_t          pending_reqs[$];   // requests still to be offered
	request_t          current_req;       // request on the input port right now
	swts_pkg::result_t expected_cmds[$];  // commands predicted but not yet seen
	swts_pkg::result_t oldest_cmd;
	logic [31:0]       model_window;      // window base the card holds in our model
	idle_phase_t       idle_phase;
	int                requests_taken;
	int                mismatches;
	int                quiet_cycles;
	logic              sender_gap;

	sdio_window_transfer_splitter_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.is_write         (is_write),
		.card_address     (card_address),
		.length           (length),
		.host_address     (host_address),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.command_index    (command_index),
		.command_argument (command_argument),
		.transfer_mode    (transfer_mode),
		.block_size_word  (block_size_word),
		.block_count      (block_count),
		.dma_address      (dma_address),
		.chunk_bytes      (chunk_bytes),
		.last             (last)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// expand one request into the command sequence the card should see
	task automatic predict_commands(input request_t rq);
		logic [31:0]       addr;
		logic [31:0]       host;
		logic [31:0]       remaining;
		logic [31:0]       offs;
		logic [31:0]       base;
		logic [31:0]       chunk;
		logic [31:0]       blocks;
		logic [16:0]       reg_addr;
		swts_pkg::result_t cmd;
		swts_pkg::result_t burst[$];
		int                k;

		addr = rq.card_address;
		host = rq.host_address;
		remaining = 32'(rq.length);
		while (remaining != 0) begin
			offs = addr & 32'(swts_pkg::WINDOW_BYTES - 1);
			base = addr - offs;
			// stop at the window edge, round down to whole blocks, cap the block count
			chunk = remaining;
			if (offs + chunk > 32'(swts_pkg::WINDOW_BYTES))
				chunk = 32'(swts_pkg::WINDOW_BYTES) - offs;
			if (chunk > 32'(swts_pkg::BLOCK_BYTES))
				chunk = chunk - (chunk % 32'(swts_pkg::BLOCK_BYTES));
			if (chunk > 32'(swts_pkg::MAX_BLOCKS * swts_pkg::BLOCK_BYTES))
				chunk = 32'(swts_pkg::MAX_BLOCKS * swts_pkg::BLOCK_BYTES);

			// window move: three direct byte writes, low byte register first
			if (base != model_window) begin
				for (k = 0; k < 3; k++) begin
					reg_addr = swts_pkg::WIN_REG_ADDR + 17'(k);
					cmd = '0;
					cmd.command_index = swts_pkg::CMD_DIRECT;
					cmd.command_argument = swts_pkg::ARG_WRITE | swts_pkg::ARG_FN1 |
						({15'd0, reg_addr} << 9) | {24'd0, base[8 + 8 * k +: 8]};
					burst.push_back(cmd);
				end
				model_window = base;
			end

			cmd = '0;
			cmd.command_index = swts_pkg::CMD_EXTENDED;
			cmd.command_argument = (rq.is_write ? swts_pkg::ARG_WRITE : 32'd0) |
				swts_pkg::ARG_FN1 | swts_pkg::ARG_INCR |
				({15'd0, offs[16:0] | swts_pkg::WIN_OFFSET} << 9);
			cmd.transfer_mode = rq.is_write ? '0 : swts_pkg::MODE_READ;
			cmd.chunk_bytes = chunk[15:0];
			if (chunk >= 32'(swts_pkg::BLOCK_BYTES)) begin
				// block mode over dma; a count of 512 wraps to zero in the argument
				blocks = chunk / 32'(swts_pkg::BLOCK_BYTES);
				cmd.command_argument |= swts_pkg::ARG_BLOCK | {23'd0, blocks[8:0]};
				cmd.transfer_mode |= swts_pkg::MODE_DMA;
				if (blocks > 1)
					cmd.transfer_mode |= swts_pkg::MODE_MULTI | swts_pkg::MODE_BCNT_EN;
				cmd.block_size_word = swts_pkg::BSZ_TAG | 16'(swts_pkg::BLOCK_BYTES);
				cmd.block_count = blocks[9:0];
				cmd.dma_address = host;
			end else begin
				// byte-mode pio tail
				cmd.command_argument |= {23'd0, chunk[8:0]};
				cmd.block_size_word = swts_pkg::BSZ_TAG | chunk[15:0];
				cmd.block_count = 10'd1;
				cmd.dma_address = '0;
			end
			burst.push_back(cmd);

			remaining = remaining - chunk;
			addr = addr + chunk;
			host = host + chunk;
		end

		// anything beyond the cap is dropped, the window still follows the whole request
		while (burst.size() > swts_pkg::RESULT_CAP)
			void'(burst.pop_back());
		if (burst.size() != 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			expected_cmds.push_back(burst[i]);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic add_request(input logic wr, input logic [31:0] card, input logic [15:0] len,
			input logic [31:0] host, input bit drain);
		request_t rq;

		rq.is_write = wr;
		rq.card_address = card;
		rq.length = len;
		rq.host_address = host;
		rq.drain_first = drain;
		pending_reqs.push_back(rq);
	endtask

	// request driver: takes the next pending request once the current one is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			is_write <= 1'b0;
			card_address <= '0;
			length <= '0;
			host_address <= '0;
			idle_phase <= PH_QUIET;
		end else begin
			if (in_valid && !in_stall) begin
				predict_commands(current_req);
				requests_taken++;
			end
			idle_phase <= idle_phase_t'((requests_taken / PHASE_REQS) % 4);

			// a stalled request stays put; otherwise load the next one or go idle
			if (!in_valid || !in_stall) begin
				sender_gap = 1'b0;
				if (idle_phase == PH_SEND)
					sender_gap = $urandom_range(0, 99) < SINGLE_PCT;
				else if (idle_phase == PH_BOTH)
					sender_gap = $urandom_range(0, 99) < BOTH_PCT;

				if (pending_reqs.size() != 0 && !sender_gap &&
						!(pending_reqs[0].drain_first && expected_cmds.size() != 0)) begin
					current_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					is_write <= current_req.is_write;
					card_address <= current_req.card_address;
					length <= current_req.length;
					host_address <= current_req.host_address;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// command monitor: each accepted command against the oldest prediction, random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_cmds.size() == 0) begin
					$error("command %0d with argument 0x%0h arrived with none predicted",
						command_index, command_argument);
					mismatches++;
				end else begin
					oldest_cmd = expected_cmds.pop_front();
					check_field("command_index", 32'(oldest_cmd.command_index), 32'(command_index));
					check_field("command_argument", oldest_cmd.command_argument, command_argument);
					check_field("transfer_mode", 32'(oldest_cmd.transfer_mode), 32'(transfer_mode));
					check_field("block_size_word", 32'(oldest_cmd.block_size_word),
						32'(block_size_word));
					check_field("block_count", 32'(oldest_cmd.block_count), 32'(block_count));
					check_field("dma_address", oldest_cmd.dma_address, dma_address);
					check_field("chunk_bytes", 32'(oldest_cmd.chunk_bytes), 32'(chunk_bytes));
					check_field("last", 32'(oldest_cmd.last), 32'(last));
				end
			end

			if (idle_phase == PH_RECV)
				out_stall <= $urandom_range(0, 99) < SINGLE_PCT;
			else if (idle_phase == PH_BOTH)
				out_stall <= $urandom_range(0, 99) < BOTH_PCT;
			else
				out_stall <= 1'b0;
		end
	end

	// watchdog: too long without a transaction on either side means a hang
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] card;
		logic [31:0] recent_base;
		logic [15:0] len;
		int          pick;

		model_window = '0;
		requests_taken = 0;
		mismatches = 0;
		quiet_cycles = 0;

		// directed requests
		// same window as reset, so no window writes; short byte-mode transfers
		add_request(1'b1, 32'h0000_0000, 16'd1, 32'h0000_0000, 1'b0);
		add_request(1'b0, 32'h0000_0010, 16'd63, 32'h1000_0000, 1'b0);
		// exactly one block, then one block plus a one-byte tail
		add_request(1'b1, 32'h0000_0040, 16'd64, 32'h2000_0040, 1'b0);
		add_request(1'b0, 32'h0000_0080, 16'd65, 32'h3000_0000, 1'b0);
		// zero length gives nothing
		add_request(1'b1, 32'h0000_0000, 16'd0, 32'hFFFF_FFFF, 1'b0);
		// window moves to 0x8000, multi-block read
		add_request(1'b0, 32'h0000_8000, 16'd128, 32'h0000_1000, 1'b0);
		// a full window in one chunk: 512 blocks, count field wraps to zero
		add_request(1'b1, 32'h0000_8000, 16'h8000, 32'h4000_0000, 1'b0);
		// longest length across windows, host address wraps
		add_request(1'b0, 32'h1234_5FF0, 16'hFFFF, 32'hFFFF_FFF0, 1'b0);
		// card address wraps past the top of the address space
		add_request(1'b1, 32'hFFFF_FFC0, 16'd200, 32'hFFFF_FFFF, 1'b0);
		add_request(1'b0, 32'hFFFF_FFFF, 16'd1, 32'hFFFF_FFFF, 1'b0);
		// three windows with a pio tail in the first and last: fourteen commands
		add_request(1'b1, 32'h1230_7FB5, 16'hFFFF, 32'h8765_4321, 1'b0);
		// moves into the next window up from the one the previous request left
		add_request(1'b0, 32'h1231_8010, 16'd16, 32'h0000_0000, 1'b0);
		// zero length elsewhere must not move the window
		add_request(1'b1, 32'hABCD_0000, 16'd0, 32'h5555_5555, 1'b0);
		add_request(1'b1, 32'h1231_8100, 16'd70, 32'hAAAA_AAAA, 1'b1);
		// top window, full size
		add_request(1'b0, 32'hFFFF_8000, 16'h8000, 32'hAAAA_5555, 1'b0);
		add_request(1'b1, 32'h5555_0040, 16'h1000, 32'h5555_AAAA, 1'b0);
		add_request(1'b0, 32'h0000_7FFF, 16'd2, 32'h0000_0001, 1'b0);

		// random requests, biased towards window edges and reuse of the current window
		recent_base = 32'hFFFF_8000;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 3)
				card = $urandom();
			else if (pick < 7)
				card = recent_base | 32'($urandom_range(0, swts_pkg::WINDOW_BYTES - 1));
			else
				card = ($urandom() & 32'hFFFF_8000) + 32'(swts_pkg::WINDOW_BYTES) -
					32'($urandom_range(1, 200));

			pick = $urandom_range(0, 19);
			if (pick == 0)
				len = '0;
			else if (pick < 7)
				len = 16'($urandom_range(1, swts_pkg::BLOCK_BYTES - 1));
			else if (pick < 11)
				len = 16'($urandom_range(swts_pkg::BLOCK_BYTES, 300));
			else if (pick < 14)
				len = 16'(swts_pkg::BLOCK_BYTES * $urandom_range(1, 16));
			else if (pick < 18)
				len = 16'($urandom_range(1, 65535));
			else if (pick == 18)
				len = 16'hFFFF;
			else
				len = 16'(swts_pkg::WINDOW_BYTES);

			// window that the last command of this request leaves programmed
			if (len != 0)
				recent_base = (card + 32'(len) - 1) & 32'hFFFF_8000;
			add_request(1'($urandom_range(0, 1)), card, len, $urandom(), n % 100 == 60);
		end

		// reset asserted at the start, released on a rising edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// every request accepted, every command seen, then a quiet tail
		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
